// File: sv/i2cm_pkg.sv
// Shared types and constants of the 16-bit register address I2C master.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_LONG_IDX   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_IDX  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_IDX = 2'd2;

  localparam logic [7:0]  LONG_RST   = 8'd5;
  localparam logic [7:0]  SHORT_RST  = 8'd2;
  localparam logic [15:0] SETTLE_RST = 16'd5000;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_ADDR_NACK   = 3'd1;
  localparam logic [2:0] STATUS_REG_NACK    = 3'd2;
  localparam logic [2:0] STATUS_DATA_NACK   = 3'd3;
  localparam logic [2:0] STATUS_RD_ADDR_NACK = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [7:0]  wr_data;
    logic        sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] rd_data;
  } out_t;

  typedef struct packed {
    logic [7:0]  long_phase_ticks;
    logic [7:0]  short_phase_ticks;
    logic [15:0] write_settle_ticks;
  } cfg_t;

endpackage

// File: sv/i2cm_in_stage.sv
// Input register of the I2C master: holds one accepted transaction.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  i2cm_pkg::in_t in_data_i,
  input  logic          take_i,
  output logic          vld_o,
  output i2cm_pkg::in_t data_o
);
  import i2cm_pkg::*;

  logic vld_q;
  in_t  data_q;

  assign in_ready_o = !vld_q || take_i;
  assign vld_o      = vld_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

// File: sv/i2cm_core.sv
// Bus sequencer of the I2C master: phase state and one tick of work per step.
// Depends on i2cm_pkg; the result is registered in i2cm_out_stage.
`timescale 1ns / 1ps

module i2cm_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2cm_pkg::in_t  item_i,
  input  i2cm_pkg::cfg_t cfg_i,
  output i2cm_pkg::out_t res_o
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C, PH_START_D,
    PH_WB_LOW, PH_WB_HIGH, PH_WB_TAIL_A, PH_WB_TAIL_B,
    PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_TAIL,
    PH_RB_PRE_A, PH_RB_PRE_B, PH_RB_LOW, PH_RB_HIGH, PH_RB_TAIL,
    PH_NACK_LOW, PH_NACK_HIGH, PH_NACK_TA, PH_NACK_TB,
    PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_STOP_D, PH_SETTLE
  } phase_e;

  typedef enum logic [1:0] {DRV_REL, DRV_LOW, DRV_BIT, DRV_LAST} drive_e;
  typedef enum logic [1:0] {LEN_LONG, LEN_SHORT, LEN_SETTLE} len_e;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [6:0]  dev_q, dev_d;
  logic [15:0] reg_q, reg_d;
  logic [7:0]  wdat_q, wdat_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic [2:0]  stat_q, stat_d;

  drive_e      drv;
  len_e        lsel;
  logic        scl;
  logic        pull;
  logic        busy;
  logic        done;
  logic [15:0] seg_len;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;

  function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic [1:0] cmd,
                                          input logic [6:0] dev, input logic [15:0] ra,
                                          input logic [7:0] wd);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {dev, 1'b0};
      3'd1:    b = ra[15:8];
      3'd2:    b = ra[7:0];
      default: b = (cmd == CMD_READ) ? {dev, 1'b1} : wd;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] nack_code(input logic [2:0] idx, input logic [1:0] cmd);
    logic [2:0] c;
    if (idx == 3'd0) begin
      c = STATUS_ADDR_NACK;
    end else if (idx <= 3'd2) begin
      c = STATUS_REG_NACK;
    end else begin
      c = (cmd == CMD_READ) ? STATUS_RD_ADDR_NACK : STATUS_DATA_NACK;
    end
    return c;
  endfunction

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    cmd_d   = cmd_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    wdat_d  = wdat_q;
    rbyte_d = rbyte_q;
    stat_d  = stat_q;
    scl     = 1'b1;
    pull    = 1'b0;
    busy    = 1'b0;
    done    = 1'b0;
    drv     = DRV_REL;
    lsel    = LEN_LONG;
    seg_len = 16'd1;
    bit_inc = bit_q + 4'd1;

    if (phase_q == PH_IDLE && item_i.action != CMD_NONE) begin
      cmd_d   = item_i.action;
      dev_d   = item_i.dev_addr;
      reg_d   = item_i.reg_addr;
      wdat_d  = item_i.wr_data;
      idx_d   = 3'd0;
      bit_d   = 4'd0;
      tick_d  = 16'd0;
      phase_d = PH_START_A;
    end

    case (phase_d)
      PH_IDLE:      begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_START_A:   begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_START_B:   begin scl = 1'b1; drv = DRV_LOW;  lsel = LEN_LONG;   end
      PH_START_C:   begin scl = 1'b0; drv = DRV_LOW;  lsel = LEN_SHORT;  end
      PH_START_D:   begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_WB_LOW:    begin scl = 1'b0; drv = DRV_BIT;  lsel = LEN_LONG;   end
      PH_WB_HIGH:   begin scl = 1'b1; drv = DRV_BIT;  lsel = LEN_LONG;   end
      PH_WB_TAIL_A: begin scl = 1'b0; drv = DRV_LAST; lsel = LEN_SHORT;  end
      PH_WB_TAIL_B: begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_ACK_LOW:   begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_ACK_HIGH:  begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_ACK_TAIL:  begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_RB_PRE_A:  begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_RB_PRE_B:  begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_RB_LOW:    begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_RB_HIGH:   begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_RB_TAIL:   begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_NACK_LOW:  begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_NACK_HIGH: begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_LONG;   end
      PH_NACK_TA:   begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_NACK_TB:   begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_STOP_A:    begin scl = 1'b0; drv = DRV_LOW;  lsel = LEN_SHORT;  end
      PH_STOP_B:    begin scl = 1'b1; drv = DRV_LOW;  lsel = LEN_SHORT;  end
      PH_STOP_C:    begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_STOP_D:    begin scl = 1'b0; drv = DRV_REL;  lsel = LEN_SHORT;  end
      PH_SETTLE:    begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_SETTLE; end
      default:      begin scl = 1'b1; drv = DRV_REL;  lsel = LEN_LONG;   end
    endcase

    case (lsel)
      LEN_LONG: begin
        seg_len = {8'd0, (cfg_i.long_phase_ticks != 8'd0) ? cfg_i.long_phase_ticks : 8'd1};
      end
      LEN_SHORT: begin
        seg_len = {8'd0, (cfg_i.short_phase_ticks != 8'd0) ? cfg_i.short_phase_ticks : 8'd1};
      end
      default: begin
        seg_len = (cfg_i.write_settle_ticks != 16'd0) ? cfg_i.write_settle_ticks : 16'd1;
      end
    endcase

    case (drv)
      DRV_LOW:  pull = 1'b1;
      DRV_BIT:  pull = !shift_d[7];
      DRV_LAST: pull = !shift_d[0];
      default:  pull = 1'b0;
    endcase

    tick_inc = tick_d + 16'd1;

    if (phase_d == PH_IDLE) begin
      scl  = 1'b1;
      pull = 1'b0;
    end else begin
      busy   = 1'b1;
      tick_d = tick_inc;
      if (tick_inc >= seg_len) begin
        tick_d = 16'd0;
        case (phase_d)
          PH_START_A:   phase_d = PH_START_B;
          PH_START_B:   phase_d = PH_START_C;
          PH_START_C:   phase_d = PH_START_D;
          PH_START_D: begin
            shift_d = byte_for(idx_d, cmd_d, dev_d, reg_d, wdat_d);
            bit_d   = 4'd0;
            phase_d = PH_WB_LOW;
          end
          PH_WB_LOW:    phase_d = PH_WB_HIGH;
          PH_WB_HIGH: begin
            shift_d = {shift_d[6:0], shift_d[7]};
            bit_d   = bit_inc;
            phase_d = (bit_inc >= 4'd8) ? PH_WB_TAIL_A : PH_WB_LOW;
          end
          PH_WB_TAIL_A: phase_d = PH_WB_TAIL_B;
          PH_WB_TAIL_B: phase_d = PH_ACK_LOW;
          PH_ACK_LOW:   phase_d = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            bit_d   = {3'd0, item_i.sda_in};
            phase_d = PH_ACK_TAIL;
          end
          PH_ACK_TAIL: begin
            if (bit_d != 4'd0) begin
              stat_d  = nack_code(idx_d, cmd_d);
              phase_d = PH_STOP_A;
            end else begin
              idx_d = idx_d + 3'd1;
              if (cmd_d == CMD_PROBE || (cmd_d == CMD_WRITE && idx_d >= 3'd4)) begin
                stat_d  = STATUS_OK;
                phase_d = PH_STOP_A;
              end else if (cmd_d == CMD_READ && idx_d == 3'd3) begin
                phase_d = PH_START_A;
              end else if (cmd_d == CMD_READ && idx_d >= 3'd4) begin
                phase_d = PH_RB_PRE_A;
              end else begin
                shift_d = byte_for(idx_d, cmd_d, dev_d, reg_d, wdat_d);
                bit_d   = 4'd0;
                phase_d = PH_WB_LOW;
              end
            end
          end
          PH_RB_PRE_A:  phase_d = PH_RB_PRE_B;
          PH_RB_PRE_B: begin
            bit_d   = 4'd0;
            shift_d = 8'd0;
            phase_d = PH_RB_LOW;
          end
          PH_RB_LOW:    phase_d = PH_RB_HIGH;
          PH_RB_HIGH: begin
            shift_d = {shift_d[6:0], item_i.sda_in};
            bit_d   = bit_inc;
            phase_d = (bit_inc >= 4'd8) ? PH_RB_TAIL : PH_RB_LOW;
          end
          PH_RB_TAIL:   phase_d = PH_NACK_LOW;
          PH_NACK_LOW:  phase_d = PH_NACK_HIGH;
          PH_NACK_HIGH: phase_d = PH_NACK_TA;
          PH_NACK_TA:   phase_d = PH_NACK_TB;
          PH_NACK_TB: begin
            rbyte_d = shift_d;
            stat_d  = STATUS_OK;
            phase_d = PH_STOP_A;
          end
          PH_STOP_A:    phase_d = PH_STOP_B;
          PH_STOP_B:    phase_d = PH_STOP_C;
          PH_STOP_C:    phase_d = PH_STOP_D;
          PH_STOP_D: begin
            if (cmd_d == CMD_WRITE && stat_d == STATUS_OK &&
                cfg_i.write_settle_ticks != 16'd0) begin
              phase_d = PH_SETTLE;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end
    end

    res_o.scl_level    = scl;
    res_o.sda_pull_low = pull;
    res_o.busy_res     = busy;
    res_o.done_res     = done;
    res_o.status       = stat_d;
    res_o.rd_data      = rbyte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 16'd0;
      bit_q   <= 4'd0;
      idx_q   <= 3'd0;
      shift_q <= 8'd0;
      cmd_q   <= CMD_NONE;
      dev_q   <= 7'd0;
      reg_q   <= 16'd0;
      wdat_q  <= 8'd0;
      rbyte_q <= 8'd0;
      stat_q  <= STATUS_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      cmd_q   <= cmd_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      wdat_q  <= wdat_d;
      rbyte_q <= rbyte_d;
      stat_q  <= stat_d;
    end
  end

endmodule

// File: sv/i2cm_out_stage.sv
// Result register of the I2C master: holds one result until it is taken.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  i2cm_pkg::out_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output i2cm_pkg::out_t out_data_o
);
  import i2cm_pkg::*;

  logic vld_q;
  out_t data_q;

  assign free_o      = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule

// File: sv/i2c_reg16_master_unit.sv
// Top level of the tick-driven I2C master for 16-bit register addresses.
// Uses i2cm_pkg, i2cm_in_stage, i2cm_core and i2cm_out_stage.
//
// Each input transaction is one bus timing tick: a command (probe, register
// write, register read or none) plus the sampled data line level. Every tick
// returns exactly one result transaction with the clock and data drive
// levels, busy, done, the last status and the last byte read.
// Input and result channels use valid/ready; the configuration port is a
// plain write port (long phase, short phase, settle ticks) used while idle.
// From input acceptance to result valid, the tick sits in the input register
// while the sequencer steps on it, and the result register loads the step's
// result once the result register is free.
// Throughput is one tick per cycle while the receiver takes results, set by
// the phase step that feeds back into the sequencer state.
// When the receiver stalls, the result register holds and the input register
// takes one more tick; input ready then drops until the result is taken.
// Reset empties both registers, returns the sequencer to idle with all state
// cleared and loads the default phase and settle lengths.
`timescale 1ns / 1ps

module i2c_reg16_master_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  i2cm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output i2cm_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cm_pkg::CfgW-1:0]     cfg_wdata_i
);
  import i2cm_pkg::*;

  cfg_t cfg_q;
  logic in_vld;
  in_t  item;
  out_t res;
  logic out_free;
  logic step;

  assign step = in_vld && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_phase_ticks   <= LONG_RST;
      cfg_q.short_phase_ticks  <= SHORT_RST;
      cfg_q.write_settle_ticks <= SETTLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_IDX:   cfg_q.long_phase_ticks   <= cfg_wdata_i[7:0];
        CFG_SHORT_IDX:  cfg_q.short_phase_ticks  <= cfg_wdata_i[7:0];
        CFG_SETTLE_IDX: cfg_q.write_settle_ticks <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  i2cm_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (step),
    .vld_o      (in_vld),
    .data_o     (item)
  );

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  i2cm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result side can move");

  a_done_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> out_data_o.busy_res)
    else $error("done without busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= STATUS_RD_ADDR_NACK))
    else $error("status code out of range");

  a_idle_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.busy_res) |->
      (out_data_o.scl_level && !out_data_o.sda_pull_low))
    else $error("bus driven while idle");
`endif

endmodule
